[rtl/best_rational_approximator_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the best rational approximator
// Shared assertion forms, clocked on i_clk; BRA_ASSERT is held off during reset.
// ----------------------------------------------------------------------------
`ifndef BEST_RATIONAL_APPROXIMATOR_CORE_ASSERT_SVH
`define BEST_RATIONAL_APPROXIMATOR_CORE_ASSERT_SVH

// Property checked at every clock edge outside of reset.
`define BRA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("best_rational_approximator assertion failed");

// Property checked at every clock edge, reset included.
`define BRA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("best_rational_approximator assertion failed");

`endif

[rtl/bra_pkg.sv]
// ----------------------------------------------------------------------------
// Best rational approximator package
// Widths, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package bra_pkg;

    localparam int WORD_W            = 64;
    localparam int ITERATION_CAP_DEF = 128;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOOP = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_ADD  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

endpackage

[rtl/bra_if.sv]
// ----------------------------------------------------------------------------
// Best rational approximator channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bra_req_if
    import bra_pkg::*;
;
    logic  valid;
    logic  ready;
    t_word frac_numerator;
    t_word frac_denominator;
    t_word denominator_limit;

    modport source (output valid, output frac_numerator, output frac_denominator,
                    output denominator_limit, input ready);
    modport sink   (input valid, input frac_numerator, input frac_denominator,
                    input denominator_limit, output ready);
endinterface

interface bra_rsp_if
    import bra_pkg::*;
;
    logic  valid;
    logic  ready;
    t_word approx_numerator;
    t_word approx_denominator;
    logic  result_status;

    modport source (output valid, output approx_numerator, output approx_denominator,
                    output result_status, input ready);
    modport sink   (input valid, input approx_numerator, input approx_denominator,
                    input result_status, output ready);
endinterface

[rtl/best_rational_approximator_core.sv]
// ----------------------------------------------------------------------------
// Best rational approximator
// Continued-fraction convergents of p/q under a denominator limit.
// ----------------------------------------------------------------------------
// One request is taken at a time, and the block shows ready only while it
// waits for one. A zero denominator or zero limit answers 0/1 with bad status,
// and the result is shown in the cycle right after the request is taken.
// Otherwise each Euclid step runs the loop test, the serial divider and the
// hand-over of its result, the shift-and-add multiplier that forms a*h1 and
// a*k1 side by side, and the final add and limit check. Fractions of 64-bit
// values need at most about 93 Euclid steps, and the cap of ITERATION_CAP
// steps bounds the walk in any case. The result waits in an output register
// until it is taken, and the next request is accepted after that.
module best_rational_approximator_core
    import bra_pkg::*;
#(
    parameter int ITERATION_CAP = ITERATION_CAP_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bra_req_if.sink   i_in,
    bra_rsp_if.source o_out
);
    localparam int W      = WORD_W;
    localparam int CNT_W  = $clog2(W);
    localparam int STEP_W = $clog2(ITERATION_CAP + 1);

    t_state r_state;
    t_state n_state;

    // Euclid remainders and the two most recent convergents.
    t_word r_p, r_q, r_limit;
    t_word r_h1, r_h2, r_k1, r_k2;
    t_word r_best_h, r_best_k;
    t_word r_a, r_r;

    // Multiplier accumulators with sticky overflow flags.
    t_word            r_acc_h, r_acc_k;
    logic             r_ov_h, r_ov_k;
    logic [CNT_W-1:0] r_bit;
    logic [STEP_W-1:0] r_step;

    // Result register.
    t_word r_out_num, r_out_den;
    logic  r_out_st;

    logic  div_start, div_done;
    t_word div_quo, div_rem;

    logic  in_acc, out_acc;
    logic  walk_end;
    logic [W:0] n_mac_h, n_mac_k;
    logic [W:0] n_sum_h, n_sum_k;
    logic  ov_h, ov_k;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    // The walk ends on the cap or once the remainder is zero.
    assign walk_end  = (r_step == STEP_W'(ITERATION_CAP)) || (r_q == '0);
    assign div_start = (r_state == ST_LOOP) && !walk_end;

    bra_div #(.W(W)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_p),
        .i_divisor   (r_q),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        // Most significant bit of a first: acc = 2*acc + bit * x.
        n_mac_h = {r_acc_h, 1'b0} + (r_a[r_bit] ? {1'b0, r_h1} : '0);
        n_mac_k = {r_acc_k, 1'b0} + (r_a[r_bit] ? {1'b0, r_k1} : '0);
        n_sum_h = {1'b0, r_acc_h} + {1'b0, r_h2};
        n_sum_k = {1'b0, r_acc_k} + {1'b0, r_k2};
        ov_h    = r_ov_h || n_sum_h[W];
        ov_k    = r_ov_k || n_sum_k[W];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.frac_denominator == '0 || i_in.denominator_limit == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_LOOP;
                    end
                end
            end
            ST_LOOP: n_state = walk_end ? ST_DONE : ST_DIV;
            ST_DIV:  if (div_done) n_state = ST_MUL;
            ST_MUL:  if (r_bit == '0) n_state = ST_ADD;
            ST_ADD: begin
                if (ov_h || ov_k || n_sum_k[W-1:0] > r_limit) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_LOOP;
                end
            end
            ST_DONE: if (out_acc) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_p      <= i_in.frac_numerator;
                r_q      <= i_in.frac_denominator;
                r_limit  <= i_in.denominator_limit;
                r_h1     <= W'(1);
                r_h2     <= '0;
                r_k1     <= '0;
                r_k2     <= W'(1);
                r_best_h <= '0;
                r_best_k <= W'(1);
                r_step   <= '0;
                r_out_num <= '0;
                r_out_den <= W'(1);
                r_out_st  <= STATUS_BAD;
            end
            ST_LOOP: begin
                if (walk_end) begin
                    r_out_num <= r_best_h;
                    r_out_den <= r_best_k;
                    r_out_st  <= STATUS_OK;
                end
            end
            ST_DIV: begin
                r_a     <= div_quo;
                r_r     <= div_rem;
                r_acc_h <= '0;
                r_acc_k <= '0;
                r_ov_h  <= 1'b0;
                r_ov_k  <= 1'b0;
                r_bit   <= CNT_W'(W - 1);
            end
            ST_MUL: begin
                // A bit shifted out of the top means the product overflowed.
                r_acc_h <= n_mac_h[W-1:0];
                r_acc_k <= n_mac_k[W-1:0];
                r_ov_h  <= r_ov_h || r_acc_h[W-1] || n_mac_h[W];
                r_ov_k  <= r_ov_k || r_acc_k[W-1] || n_mac_k[W];
                r_bit   <= r_bit - 1'b1;
            end
            ST_ADD: begin
                if (ov_h || ov_k || n_sum_k[W-1:0] > r_limit) begin
                    r_out_num <= r_best_h;
                    r_out_den <= r_best_k;
                    r_out_st  <= STATUS_OK;
                end else begin
                    r_best_h <= n_sum_h[W-1:0];
                    r_best_k <= n_sum_k[W-1:0];
                    r_h2     <= r_h1;
                    r_h1     <= n_sum_h[W-1:0];
                    r_k2     <= r_k1;
                    r_k1     <= n_sum_k[W-1:0];
                    r_p      <= r_q;
                    r_q      <= r_r;
                    r_step   <= r_step + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready               = (r_state == ST_IDLE);
    assign o_out.valid              = (r_state == ST_DONE);
    assign o_out.approx_numerator   = r_out_num;
    assign o_out.approx_denominator = r_out_den;
    assign o_out.result_status      = r_out_st;
endmodule

[rtl/bra_div.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bra_div
    import bra_pkg::*;
#(
    parameter int W = WORD_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);
    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_dsr;
    logic             r_done;
    logic [W:0]       n_trial;
    logic [W:0]       n_shift;

    always_comb begin
        n_shift = {r_rem, r_quo[W-1]};
        n_trial = n_shift - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                // The trial difference going negative means the bit is zero.
                if (!n_trial[W]) begin
                    r_rem <= n_trial[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

[rtl/bra_checker.sv]
// ----------------------------------------------------------------------------
// Best rational approximator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "best_rational_approximator_core_assert.svh"

module bra_checker
    import bra_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_word i_out_num,
    input t_word i_out_den,
    input logic  i_out_st
);
    // A result waits until it is taken.
    `BRA_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid)
    // One request at a time: no intake while a result is shown.
    `BRA_ASSERT(a_one_at_a_time, !(i_in_ready && i_out_valid))
    // A taken request closes the intake on the next cycle.
    `BRA_ASSERT(a_busy_after_take, i_in_valid && i_in_ready |=> !i_in_ready)
    // A bad request answers exactly 0/1.
    `BRA_ASSERT(a_bad_is_zero, i_out_valid && i_out_st == STATUS_BAD |->
        i_out_num == '0 && i_out_den == t_word'(1))
    // A result always has a nonzero denominator.
    `BRA_ASSERT(a_den_nonzero, i_out_valid |-> i_out_den != '0)
endmodule

bind best_rational_approximator_core bra_checker u_bra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_num   (o_out.approx_numerator),
    .i_out_den   (o_out.approx_denominator),
    .i_out_st    (o_out.result_status)
);
